// ===== sv/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// Least-squares slope package
// Shared widths, status codes, payload structs and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lss_pkg;

   localparam int MAX_SAMPLES = 1024;

   // The count must also hold the overflow mark MAX_SAMPLES + 1.
   localparam int CNT_W = $clog2(MAX_SAMPLES + 2);
   // Working x width: a 16-bit sample or a sample position.
   localparam int X_W   = (CNT_W + 1 > 17) ? CNT_W + 1 : 17;
   localparam int SX_W  = X_W + CNT_W - 1;
   localparam int SXY_W = X_W + CNT_W + 14;
   localparam int SXX_W = 2 * X_W + CNT_W - 2;
   localparam int SQ_W  = (SXX_W > SXY_W) ? SXX_W : SXY_W;
   localparam int PA_W  = CNT_W + 1 + SQ_W;
   localparam int PB_W  = 2 * SX_W;
   localparam int NUM_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
   localparam int MAG_W = NUM_W - 1;
   localparam int FRAC_W = 16;
   localparam int QUO_W  = 32;
   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);
   localparam logic [CNT_W-1:0] OVF_CNT = CNT_W'(MAX_SAMPLES + 1);

   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   typedef struct packed {
      logic signed [15:0] x_sample;
      logic signed [15:0] y_sample;
      logic               last_sample;
   } lss_req_type;

   typedef struct packed {
      logic signed [31:0] slope_q16;
      logic [1:0]         result_status;
   } lss_rsp_type;

   typedef struct packed {
      logic acc;       // add the accepted word to the sums
      logic mul_num;   // form the numerator products
      logic mul_den;   // form the denominator products, latch the numerator
      logic dif_den;   // latch the denominator and the numerator magnitude
      logic chk;       // classify and load the divider
      logic div_step;  // one restoring division step
      logic rnd;       // round the quotient
      logic fin;       // load the result register and clear the sums
   } lss_cmd_type;

   typedef struct packed {
      logic early;     // result known without division
      logic out_full;  // result register cannot take a new word
   } lss_sts_type;

endpackage

// ===== sv/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Least-squares slope controller
// Sequences accumulation, the product steps, the bit-serial divider and the
// result hand-off.
// ----------------------------------------------------------------------------
module lss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_stall,
   input  lss_pkg::lss_sts_type sts,
   output lss_pkg::lss_cmd_type cmd
);
   import lss_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MNUM = 3'd1;
   localparam logic [2:0] S_MDEN = 3'd2;
   localparam logic [2:0] S_DDEN = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_RND  = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.acc = accept;
            if (accept && req_last) begin
               state_in = S_MNUM;
            end
         end
         S_MNUM: begin
            cmd.mul_num = 1'b1;
            state_in    = S_MDEN;
         end
         S_MDEN: begin
            cmd.mul_den = 1'b1;
            state_in    = S_DDEN;
         end
         S_DDEN: begin
            cmd.dif_den = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            cmd.chk    = 1'b1;
            div_cnt_in = '0;
            state_in   = sts.early ? S_FIN : S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               div_cnt_in = '0;
               state_in   = S_RND;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_RND: begin
            cmd.rnd  = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_full) begin
               cmd.fin  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // The step counter only runs while the divider is busy.
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DIV) |-> (div_cnt_ff == '0))
      else $error("divider step counter active outside division");

   // A last word always starts the final computation.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last) |=> (state_ff == S_MNUM))
      else $error("last word did not start the slope computation");

   // A finished result waits while the result register is occupied.
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && sts.out_full) |=> (state_ff == S_FIN))
      else $error("result dropped while output was stalled");

endmodule

// ===== sv/lss_dpath.sv =====
// ----------------------------------------------------------------------------
// Least-squares slope datapath
// Running sums, the product and difference registers, a bit-serial restoring
// divider, rounding, saturation and the result register.
// ----------------------------------------------------------------------------
module lss_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  lss_pkg::lss_cmd_type cmd,
   output lss_pkg::lss_sts_type sts,
   input  lss_pkg::lss_req_type req_data,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output lss_pkg::lss_rsp_type rsp_data
);
   import lss_pkg::*;

   logic                     index_mode_ff;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [SX_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SXY_W-1:0]  sxy_ff, sxy_in;
   logic signed [SXX_W-1:0]  sxx_ff, sxx_in;

   logic signed [X_W-1:0]    x_val;
   logic signed [SXY_W-1:0]  xy_prod;
   logic signed [SXX_W-1:0]  xx_prod;

   logic signed [NUM_W-1:0]  op_a, op_b, op_c, op_d;
   logic signed [NUM_W-1:0]  pa_ff, pb_ff, num_ff, den_ff;
   logic [MAG_W-1:0]         mag_ff, mag_in, mag_hi, den_u;
   logic                     neg_ff;

   logic                     ovf, den_bad, big;
   logic [1:0]               code_ff, code_in;

   logic [MAG_W-1:0]         rem_ff, rem_in;
   logic [MAG_W:0]           rem_sh, den_ext;
   logic                     ge;
   logic [QUO_W-1:0]         dvd_ff, quot_ff;
   logic                     rnd_up;
   logic [QUO_W:0]           res_ff;

   logic [31:0]              sat_val, res_lo;
   logic                     over;
   lss_rsp_type              rsp_ff, rsp_in;
   logic                     rsp_valid_ff;

   // ---------------- accumulation ----------------
   assign x_val = index_mode_ff ? signed'({{(X_W-CNT_W){1'b0}}, cnt_ff})
                                : signed'({{(X_W-16){req_data.x_sample[15]}},
                                           req_data.x_sample});
   assign xy_prod = SXY_W'(x_val) * SXY_W'(req_data.y_sample);
   assign xx_prod = SXX_W'(x_val) * SXX_W'(x_val);

   always_comb begin
      cnt_in = cnt_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sxy_in = sxy_ff;
      sxx_in = sxx_ff;
      if (cmd.fin) begin
         cnt_in = '0;
         sx_in  = '0;
         sy_in  = '0;
         sxy_in = '0;
         sxx_in = '0;
      end else if (cmd.acc) begin
         if (cnt_ff < MAX_CNT) begin
            cnt_in = cnt_ff + 1'b1;
            sx_in  = sx_ff + SX_W'(x_val);
            sy_in  = sy_ff + SX_W'(req_data.y_sample);
            sxy_in = sxy_ff + xy_prod;
            sxx_in = sxx_ff + xx_prod;
         end else begin
            cnt_in = OVF_CNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_mode_ff <= 1'b0;
         cnt_ff        <= '0;
         sx_ff         <= '0;
         sy_ff         <= '0;
         sxy_ff        <= '0;
         sxx_ff        <= '0;
      end else begin
         if (csr_we) begin
            index_mode_ff <= csr_wdata;
         end
         cnt_ff <= cnt_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sxy_ff <= sxy_in;
         sxx_ff <= sxx_in;
      end
   end

   // ---------------- products and differences ----------------
   // Numerator n*Sxy - Sx*Sy, then denominator n*Sxx - Sx*Sx, on the same
   // pair of multipliers.
   assign op_a = signed'(NUM_W'({1'b0, cnt_ff}));
   assign op_b = cmd.mul_num ? NUM_W'(sxy_ff) : NUM_W'(sxx_ff);
   assign op_c = NUM_W'(sx_ff);
   assign op_d = cmd.mul_num ? NUM_W'(sy_ff) : NUM_W'(sx_ff);
   assign mag_in = num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_num || cmd.mul_den) begin
         pa_ff <= op_a * op_b;
         pb_ff <= op_c * op_d;
      end
      if (cmd.mul_den) begin
         num_ff <= pa_ff - pb_ff;
      end
      if (cmd.dif_den) begin
         den_ff <= pa_ff - pb_ff;
         mag_ff <= mag_in;
         neg_ff <= num_ff[NUM_W-1];
      end
   end

   // ---------------- classification ----------------
   // The integer part overflows 16 bits exactly when mag / 2^16 >= den.
   assign mag_hi  = {{FRAC_W{1'b0}}, mag_ff[MAG_W-1:FRAC_W]};
   assign den_u   = den_ff[MAG_W-1:0];
   assign ovf     = (cnt_ff > MAX_CNT);
   assign den_bad = (den_ff == '0) || den_ff[NUM_W-1];
   assign big     = (mag_hi >= den_u);

   always_comb begin
      if (ovf) begin
         code_in = ST_OVF;
      end else if (den_bad) begin
         code_in = ST_ZERO;
      end else if (big) begin
         code_in = ST_SAT;
      end else begin
         code_in = ST_OK;
      end
   end

   assign sts.early    = ovf || den_bad || big;
   assign sts.out_full = rsp_valid_ff && rsp_stall;

   // ---------------- bit-serial divider ----------------
   // Divides mag * 2^16 by den; the upper part mag / 2^16 is below den, so
   // it seeds the partial remainder and 32 quotient bits follow.
   assign rem_sh  = {rem_ff, dvd_ff[QUO_W-1]};
   assign den_ext = {1'b0, den_u};
   assign ge      = (rem_sh >= den_ext);
   assign rem_in  = ge ? MAG_W'(rem_sh - den_ext) : MAG_W'(rem_sh);
   assign rnd_up  = ({rem_ff, 1'b0} >= den_ext);

   always_ff @(posedge clock) begin
      if (cmd.chk) begin
         code_ff <= code_in;
         rem_ff  <= mag_hi;
         dvd_ff  <= {mag_ff[FRAC_W-1:0], {(QUO_W-FRAC_W){1'b0}}};
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         dvd_ff  <= {dvd_ff[QUO_W-2:0], 1'b0};
         quot_ff <= {quot_ff[QUO_W-2:0], ge};
      end
      if (cmd.rnd) begin
         res_ff <= {1'b0, quot_ff} + (QUO_W+1)'(rnd_up);
      end
   end

   // ---------------- result ----------------
   assign sat_val = neg_ff ? SAT_NEG : SAT_POS;
   assign over    = (res_ff > {1'b0, sat_val});
   assign res_lo  = res_ff[31:0];

   always_comb begin
      rsp_in = '0;
      case (code_ff)
         ST_OK: begin
            if (over) begin
               rsp_in.slope_q16     = sat_val;
               rsp_in.result_status = ST_SAT;
            end else begin
               rsp_in.slope_q16     = neg_ff ? (~res_lo + 32'd1) : res_lo;
               rsp_in.result_status = ST_OK;
            end
         end
         ST_SAT: begin
            rsp_in.slope_q16     = sat_val;
            rsp_in.result_status = ST_SAT;
         end
         default: begin
            rsp_in.slope_q16     = '0;
            rsp_in.result_status = code_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/least_squares_slope_top.sv =====
// Ordinary words are taken one per cycle; the word marked last stalls input
// until its result is loaded. That word leads to the numerator and denominator
// products, the differences, classification, the 32-step bit-serial divider
// and rounding; zero denominator, early saturation or too many samples skip
// the divider and rounding. A stalled result delays the next set further.
// Reset (synchronous, active high) clears the count, sums, mode and output valid.
// ----------------------------------------------------------------------------
// Least-squares slope top level
// Accumulates sample sums and returns the regression slope in Q16.16 with a
// status code for every set.
// ----------------------------------------------------------------------------
module least_squares_slope_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lss_pkg::lss_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lss_pkg::lss_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_wdata
);
   import lss_pkg::*;

   lss_cmd_type cmd;
   lss_sts_type sts;

   // The mode register is always writable.
   assign csr_ready = 1'b1;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_sample),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lss_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
